// ----- rtl/tts_pkg.sv -----
`default_nettype none
package tts_pkg;
  localparam int LANES = 8;
  localparam int CNT_W = 12;
  localparam int Q_W = 17;
  localparam int IDX_W = 32;
  localparam int ROW_W = 29;
  localparam int COL_W = 11;
  localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic OP_MASK = 1'b0;
  localparam logic OP_ROW = 1'b1;

  localparam logic [1:0] REG_QUERY_ONES = 2'd0;
  localparam logic [1:0] REG_ITEM_ONES = 2'd1;
  localparam logic [1:0] REG_LOWER = 2'd2;
  localparam logic [1:0] REG_UPPER = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [7:0] value;
    logic [ROW_W-1:0] row_index;
    logic row_last;
    logic opcode;
  } in_item_t;

  typedef struct packed {
    logic start;
    logic [CNT_W-1:0] inter;
    logic [CNT_W:0] den;
  } div_req_t;
endpackage
`default_nettype wire

// ----- rtl/tts_lane.sv -----
`default_nettype none
module tts_lane
  import tts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic bit_add,
  input  wire logic clear,
  input  wire div_req_t req,
  output logic [CNT_W-1:0] count,
  output logic done,
  output logic [Q_W-1:0] score
);
  localparam int NUM_W = CNT_W + 16 + 1;
  localparam int STEP_W = 5;

  logic [NUM_W-1:0] num;
  logic [CNT_W:0] den;
  logic [CNT_W+1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic busy;
  logic zero_den;
  logic [CNT_W+1:0] trial;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (bit_add && count != COUNT_MAX) begin
      count <= count + 1'b1;
    end
  end

  assign trial = {rem[CNT_W:0], num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(NUM_W);
        num <= ({1'b0, req.inter, 16'd0}) + NUM_W'(req.den >> 1);
        den <= req.den;
        zero_den <= (req.den == '0);
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_den) score = '0;
    else if (quo > NUM_W'(ONE_Q16)) score = ONE_Q16;
    else score = quo[Q_W-1:0];
  end
endmodule
`default_nettype wire

// ----- rtl/tts_merge.sv -----
`default_nettype none
module tts_merge
  import tts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic [LANES-1:0] hit,
  input  wire logic [LANES-1:0][Q_W-1:0] scores,
  input  wire logic [ROW_W-1:0] row_index,
  output logic busy,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [55:0] m_axis_tdata,
  output logic m_axis_tlast
);
  logic [LANES-1:0] pend;
  logic [LANES-1:0][Q_W-1:0] sc;
  logic [ROW_W-1:0] row;
  logic [2:0] sel;
  logic [LANES-1:0] rest;

  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend[i]) sel = 3'(i);
    end
    rest = pend & ~(LANES'(1) << sel);
  end

  assign busy = (pend != '0) || m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pend <= hit;
        sc <= scores;
        row <= row_index;
      end else if (pend != '0 && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {7'd0, sc[sel], {row, sel}};
        m_axis_tlast <= (rest == '0);
        pend <= rest;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tanimoto_threshold_search.sv -----
// Tanimoto threshold search.
// Input stream (s_axis): tdata holds column, value, row_index; tuser is the
// opcode (0 mask write, 1 row byte); tlast marks the last byte of a row.
// Mask writes and row bytes are taken one per cycle while s_axis_tready is
// high. On a row byte with tlast, eight lane dividers start in the next
// cycle (unless query_ones is zero) and run in parallel, one quotient bit
// per cycle in each lane. When they finish, their scores and hit flags are
// loaded into the merge stage, which emits one transfer per hit in lane
// order, tlast on the final hit. Input stalls from row end until the merge
// stage has sent the final hit and the state machine is back in run; when
// query_ones is zero no hit is sent. Mid-row bytes flow one per cycle.
// Output stream (m_axis): tdata holds item_index, score_q16; tlast last_hit.
// A stalled receiver holds the current hit; later hits wait in the merger.
// After reset a pass over all FP_BITS (2048 by default) entries clears the
// query mask, taking no input. Configuration writes go through cfg_*.
`default_nettype none
module tanimoto_threshold_search
  import tts_pkg::*;
#(
  parameter int FP_BITS = 2048
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [47:0] s_axis_tdata, // column, value, row_index
  input  wire logic s_axis_tuser,        // opcode
  input  wire logic s_axis_tlast,        // row_last
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [55:0] m_axis_tdata,      // item_index, score_q16
  output logic m_axis_tlast              // last_hit
);
  localparam int MW = (FP_BITS > 1) ? $clog2(FP_BITS) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001, ST_RUN = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [MW-1:0] clr_addr;
  logic mask [FP_BITS];
  logic [11:0] query_ones, item_ones;
  logic [16:0] lower_q16, upper_q16;

  logic [COL_W-1:0] column;
  logic [7:0] value;
  logic [ROW_W-1:0] row_index;
  logic acc;
  logic in_range;

  logic p_valid, p_last, p_mask;
  logic [7:0] p_value;
  logic [ROW_W-1:0] p_row, row_hold;
  logic [LANES-1:0] div_done;
  logic [LANES-1:0][CNT_W-1:0] counts;
  logic [LANES-1:0][Q_W-1:0] scores;
  logic [LANES-1:0] hit;
  div_req_t [LANES-1:0] req;
  logic start, clear, load, merge_busy, qz;

  assign column = s_axis_tdata[10:0];
  assign value = s_axis_tdata[18:11];
  assign row_index = s_axis_tdata[47:19];
  assign acc = s_axis_tvalid && s_axis_tready;
  assign in_range = ({21'd0, column} < 32'(FP_BITS));
  assign s_axis_tready = (state == ST_RUN) && !(p_valid && p_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_ones <= '0;
      item_ones <= '0;
      lower_q16 <= '0;
      upper_q16 <= ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_ONES: query_ones <= cfg_data[11:0];
        REG_ITEM_ONES: item_ones <= cfg_data[11:0];
        REG_LOWER: lower_q16 <= cfg_data;
        REG_UPPER: upper_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mask[clr_addr] <= 1'b0;
    end else if (acc && s_axis_tuser == OP_MASK && in_range) begin
      mask[MW'(column)] <= value[0];
    end
    p_mask <= in_range && mask[MW'(column)];
    p_value <= value;
    p_row <= row_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last <= 1'b0;
    end else begin
      p_valid <= acc && s_axis_tuser == OP_ROW;
      p_last <= acc && s_axis_tuser == OP_ROW && s_axis_tlast;
    end
  end

  assign start = (state == ST_RUN) && p_valid && p_last;
  assign clear = load || (start && qz);
  assign load = (state == ST_DIV) && div_done[0];
  assign qz = (query_ones == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MW'(FP_BITS - 1)) state <= ST_RUN;
        end
        ST_RUN: begin
          if (start && !qz) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done[0]) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!merge_busy) state <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) row_hold <= p_row;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [CNT_W-1:0] cnow;
    logic [CNT_W+1:0] dsum;
    assign cnow = (counts[g] != COUNT_MAX && p_mask && p_value[7-g])
                ? counts[g] + 1'b1 : counts[g];
    assign dsum = {2'b0, query_ones} + {2'b0, item_ones} - {2'b0, cnow};
    assign req[g].start = start && !qz;
    assign req[g].inter = cnow;
    assign req[g].den = (dsum[CNT_W+1] || dsum == '0) ? '0 : dsum[CNT_W:0];
    assign hit[g] = (scores[g] >= lower_q16) && (scores[g] <= upper_q16);
    tts_lane u_lane (
      .clk(clk), .rst(rst),
      .bit_add(p_valid && p_mask && p_value[7-g] && (state == ST_RUN)),
      .clear(clear), .req(req[g]),
      .count(counts[g]), .done(div_done[g]), .score(scores[g])
    );
  end

  tts_merge u_merge (
    .clk(clk), .rst(rst), .load(load), .hit(hit), .scores(scores),
    .row_index(row_hold), .busy(merge_busy),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );
endmodule
`default_nettype wire

// ----- rtl/tts_checker.sv -----
`default_nettype none
module tts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_score: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[48:32] <= 17'd65536)
    else $error("score above one");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
    else $error("padding set");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid && !s_axis_tready)
    else $error("active after reset");
endmodule
bind tanimoto_threshold_search tts_checker u_chk (.*);
`default_nettype wire
